/* design/wlet_pkg.sv */
// Shared types, codes and helpers of the weekly light event table.
`timescale 1ns / 1ps

package wlet_pkg;

    localparam int EVENT_SLOTS_DEF = 64;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    localparam logic [3:0] CODE_EVERYDAY = 4'd7;
    localparam logic [3:0] CODE_WEEKDAY  = 4'd8;
    localparam logic [3:0] CODE_WEEKEND  = 4'd9;

    localparam logic [2:0] DAY_SUNDAY   = 3'd0;
    localparam logic [2:0] DAY_MONDAY   = 3'd1;
    localparam logic [2:0] DAY_FRIDAY   = 3'd5;
    localparam logic [2:0] DAY_SATURDAY = 3'd6;

    typedef struct packed {
        logic        op;
        logic [7:0]  light_id;
        logic [3:0]  day_code;
        logic        action;
        logic [10:0] minute;
        logic [2:0]  today;
    } item_t;

    typedef struct packed {
        logic       fired;
        logic [7:0] out_light;
        logic       out_action;
        logic       last;
    } result_t;

    // stored event, same bit layout as the slot word
    typedef struct packed {
        logic [10:0] minute;
        logic        action;
        logic [3:0]  day_code;
        logic [7:0]  light;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } state_t;

    function automatic logic day_matches(input logic [3:0] code, input logic [2:0] today);
        logic hit;
        hit = 1'b0;
        if (code == CODE_EVERYDAY)
        begin
            hit = 1'b1;
        end
        if (code == {1'b0, today})
        begin
            hit = 1'b1;
        end
        if (code == CODE_WEEKEND && (today == DAY_SATURDAY || today == DAY_SUNDAY))
        begin
            hit = 1'b1;
        end
        if (code == CODE_WEEKDAY && today >= DAY_MONDAY && today <= DAY_FRIDAY)
        begin
            hit = 1'b1;
        end
        return hit;
    endfunction

endpackage

/* design/wlet_mem.sv */
// Slot memory: one write port, one read port, registered read data.
`timescale 1ns / 1ps

module wlet_mem #(
    parameter int DEPTH = wlet_pkg::EVENT_SLOTS_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [wlet_pkg::ENTRY_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [wlet_pkg::ENTRY_W-1:0] rd_data
);

    logic [wlet_pkg::ENTRY_W-1:0] mem [DEPTH];
    logic [wlet_pkg::ENTRY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read data holds while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/wlet_ctrl.sv */
// Sequencer: slot allocation, tick scan over the slot memory, result register.
`timescale 1ns / 1ps

module wlet_ctrl #(
    parameter int EVENT_SLOTS = wlet_pkg::EVENT_SLOTS_DEF,
    localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  wlet_pkg::item_t               item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output wlet_pkg::result_t             result,
    output logic                          wr_en,
    output logic [AW-1:0]                 wr_addr,
    output logic [wlet_pkg::ENTRY_W-1:0]  wr_data,
    output logic                          rd_en,
    output logic [AW-1:0]                 rd_addr,
    input  logic [wlet_pkg::ENTRY_W-1:0]  rd_data
);

    localparam int CW = $clog2(EVENT_SLOTS + 1);

    wlet_pkg::state_t  state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [2:0]        today_reg, today_next;
    logic [10:0]       minute_reg, minute_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [7:0]        pend_light_reg, pend_light_next;
    logic              pend_action_reg, pend_action_next;
    logic              out_valid_reg, out_valid_next;
    wlet_pkg::result_t out_reg, out_next;

    wlet_pkg::entry_t  entry;
    wlet_pkg::entry_t  new_entry;
    logic              accept;
    logic              out_free;
    logic              hit;
    logic              scan_end;
    logic              scan_step;
    logic              push;
    wlet_pkg::result_t push_data;

    // slots are freed only by reset, so used slots form a prefix and the fill count is the free slot
    assign entry     = wlet_pkg::entry_t'(rd_data);
    assign accept    = item_valid && item_ready;
    assign out_free  = !out_valid_reg || result_ready;
    assign hit       = wlet_pkg::day_matches(entry.day_code, today_reg)
                       && (entry.minute == minute_reg);
    assign scan_end  = (CW'(addr_reg) + CW'(1)) == count_reg;
    // a second hit has to push the held one out first
    assign scan_step = !(hit && pend_valid_reg) || out_free;

    always_comb
    begin
        new_entry.minute   = item.minute;
        new_entry.action   = item.action;
        new_entry.day_code = item.day_code;
        new_entry.light    = item.light_id;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            wlet_pkg::ST_IDLE:
            begin
                if (item_valid && item.op == wlet_pkg::OP_TICK)
                begin
                    state_next = (count_reg == '0) ? wlet_pkg::ST_FLUSH : wlet_pkg::ST_SCAN;
                end
            end
            wlet_pkg::ST_SCAN:
            begin
                if (scan_step && scan_end)
                begin
                    state_next = wlet_pkg::ST_FLUSH;
                end
            end
            wlet_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = wlet_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wlet_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        item_ready       = 1'b0;
        wr_en            = 1'b0;
        wr_addr          = count_reg[AW-1:0];
        wr_data          = new_entry;
        rd_en            = 1'b0;
        rd_addr          = '0;
        push             = 1'b0;
        push_data        = '0;
        count_next       = count_reg;
        addr_next        = addr_reg;
        today_next       = today_reg;
        minute_next      = minute_reg;
        pend_valid_next  = pend_valid_reg;
        pend_light_next  = pend_light_reg;
        pend_action_next = pend_action_reg;
        case (state_reg)
            wlet_pkg::ST_IDLE:
            begin
                item_ready = 1'b1;
                if (accept && item.op == wlet_pkg::OP_SCHEDULE)
                begin
                    if (count_reg < CW'(EVENT_SLOTS))
                    begin
                        wr_en      = 1'b1;
                        count_next = count_reg + CW'(1);
                    end
                end
                else if (accept)
                begin
                    today_next      = item.today;
                    minute_next     = item.minute;
                    pend_valid_next = 1'b0;
                    addr_next       = '0;
                    rd_en           = (count_reg != '0);
                end
            end
            wlet_pkg::ST_SCAN:
            begin
                if (scan_step)
                begin
                    if (hit)
                    begin
                        push                 = pend_valid_reg;
                        push_data.fired      = 1'b1;
                        push_data.out_light  = pend_light_reg;
                        push_data.out_action = pend_action_reg;
                        push_data.last       = 1'b0;
                        pend_valid_next      = 1'b1;
                        pend_light_next      = entry.light;
                        pend_action_next     = entry.action;
                    end
                    if (!scan_end)
                    begin
                        addr_next = addr_reg + AW'(1);
                        rd_en     = 1'b1;
                        rd_addr   = addr_reg + AW'(1);
                    end
                end
            end
            wlet_pkg::ST_FLUSH:
            begin
                push                 = out_free;
                push_data.fired      = pend_valid_reg;
                push_data.out_light  = pend_valid_reg ? pend_light_reg : 8'd0;
                push_data.out_action = pend_valid_reg && pend_action_reg;
                push_data.last       = 1'b1;
                if (out_free)
                begin
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (push)
        begin
            out_valid_next = 1'b1;
            out_next       = push_data;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= wlet_pkg::ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        today_reg       <= today_next;
        minute_reg      <= minute_next;
        pend_light_reg  <= pend_light_next;
        pend_action_reg <= pend_action_next;
        out_reg         <= out_next;
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

/* design/weekly_light_event_table.sv */
// Top level of the weekly light event table.
`timescale 1ns / 1ps

// Weekly light event table.
// Input channel item_valid/item_ready/item carries one beat per item: op selects
// schedule (store light, day code, minute, action in the next free slot) or tick
// (today and current minute). Results leave on result_valid/result_ready/result.
// A schedule beat gives no result; with every slot in use it is dropped. A tick
// reads the used slots one per cycle, unless a stalled receiver holds the scan,
// through the single read port of the slot memory. Each matching slot gives one
// beat in slot order; the final beat of a tick has last set, and a tick without
// a match gives one beat with fired clear.
// A finished result sits in an output register, so a new item is taken while it
// waits; a stalled receiver holds the scan only when a further result is due.
// Reset frees every slot at once and discards the stored events as well as any
// pending result and any result waiting in the output register.
module weekly_light_event_table #(
    parameter int EVENT_SLOTS = wlet_pkg::EVENT_SLOTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  wlet_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output wlet_pkg::result_t result
);

    localparam int AW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;

    logic                         wr_en;
    logic [AW-1:0]                wr_addr;
    logic [wlet_pkg::ENTRY_W-1:0] wr_data;
    logic                         rd_en;
    logic [AW-1:0]                rd_addr;
    logic [wlet_pkg::ENTRY_W-1:0] rd_data;

    wlet_ctrl #(
        .EVENT_SLOTS(EVENT_SLOTS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result),
        .wr_en       (wr_en),
        .wr_addr     (wr_addr),
        .wr_data     (wr_data),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    wlet_mem #(
        .DEPTH(EVENT_SLOTS)
    ) u_mem (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    // a taken tick drops item_ready while its scan and flush run
    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.op == wlet_pkg::OP_TICK) |=> !item_ready)
        else $error("item taken straight after a tick");

    // schedule beats never stall the input
    a_sched_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready && item.op == wlet_pkg::OP_SCHEDULE) |=> item_ready)
        else $error("input stalled after a schedule beat");

    // a no-match beat is the only beat of its tick and carries no action
    a_nofire_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.fired) |->
        (result.last && result.out_light == 8'd0 && !result.out_action))
        else $error("malformed no-match result");

    // memory read and write never collide
    a_mem_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("slot memory read and write in the same cycle");

endmodule
